/* hw/rtl/sv39ptb_pkg.sv */
// Shared types and constants of the Sv39 page table builder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sv39ptb_pkg;

   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int VPN_W            = 27;
   localparam int PPN_W            = 44;
   localparam int CNT_W            = 16;
   localparam int PERM_W           = 8;
   localparam int ENTRY_W          = 64;
   localparam int USED_W           = 5;
   localparam int FLAG_SHIFT       = 10;
   localparam int FLAG_V_BIT       = 0;
   localparam int FLAG_U_BIT       = 4;

   localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'h0_0000_0008_0000;

   localparam logic CMD_MAP  = 1'b0;
   localparam logic CMD_MARK = 1'b1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_MAPPED   = 3'd1,
      ST_UNMAPPED = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_FOREIGN  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      LVL_0 = 2'd0,
      LVL_1 = 2'd1,
      LVL_2 = 2'd2
   } level_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       rd;
      logic       clr_step;
      logic       clr_root;
      logic       link;
      logic       descend;
      logic       leaf_wr;
      logic       set_st;
      status_type st;
      logic       out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic start_empty;
      logic entry_zero;
      logic foreign;
      logic pool_full;
      logic level_zero;
      logic is_mark;
      logic last_page;
      logic clr_last;
   } dp_sts_type;

endpackage

`default_nettype wire

/* hw/rtl/sv39ptb_req_if.sv */
// Request channel interface of the Sv39 page table builder.
// Depends on sv39ptb_pkg for the field widths.
`default_nettype none

interface sv39ptb_req_if import sv39ptb_pkg::*; ();

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [VPN_W-1:0]  virt_page;
   logic [PPN_W-1:0]  phys_page;
   logic [CNT_W-1:0]  page_count;
   logic [PERM_W-1:0] permissions;

   modport source (output valid, cmd, virt_page, phys_page, page_count, permissions,
                   input ready);
   modport sink   (input valid, cmd, virt_page, phys_page, page_count, permissions,
                   output ready);

endinterface

`default_nettype wire

/* hw/rtl/sv39ptb_rsp_if.sv */
// Response channel interface of the Sv39 page table builder.
// Depends on sv39ptb_pkg for the field widths.
`default_nettype none

interface sv39ptb_rsp_if import sv39ptb_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [ENTRY_W-1:0] last_entry;
   logic [CNT_W-1:0]   pages_done;
   logic [USED_W-1:0]  pool_pages_used;

   modport source (output valid, status, last_entry, pages_done, pool_pages_used,
                   input ready);
   modport sink   (input valid, status, last_entry, pages_done, pool_pages_used,
                   output ready);

endinterface

`default_nettype wire

/* hw/rtl/sv39ptb_ctrl.sv */
// Controller state machine of the Sv39 page table builder.
// Depends on sv39ptb_pkg; drives the datapath through dp_cmd_type.
`default_nettype none

module sv39ptb_ctrl import sv39ptb_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire dp_sts_type sts,
   output dp_cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_INIT  = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_CHECK = 7'b0001000,
      S_CLEAR = 7'b0010000,
      S_LINK  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_INIT: begin
            // Sweep the root table to zero after reset.
            cmd.clr_step = 1'b1;
            cmd.clr_root = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sts.start_empty ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!sts.level_zero) begin
               if (sts.entry_zero) begin
                  if (sts.is_mark) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_UNMAPPED;
                     state_in   = S_DONE;
                  end else if (sts.pool_full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = ST_EMPTY;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_CLEAR;
                  end
               end else if (sts.foreign) begin
                  cmd.set_st = 1'b1;
                  cmd.st     = ST_FOREIGN;
                  state_in   = S_DONE;
               end else begin
                  cmd.descend = 1'b1;
                  state_in    = S_READ;
               end
            end else if (sts.is_mark) begin
               if (sts.entry_zero) begin
                  cmd.set_st = 1'b1;
                  cmd.st     = ST_UNMAPPED;
               end else begin
                  cmd.leaf_wr = 1'b1;
               end
               state_in = S_DONE;
            end else if (!sts.entry_zero) begin
               cmd.set_st = 1'b1;
               cmd.st     = ST_MAPPED;
               state_in   = S_DONE;
            end else begin
               cmd.leaf_wr = 1'b1;
               state_in    = sts.last_page ? S_DONE : S_READ;
            end
         end
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.link = 1'b1;
            state_in = S_READ;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* hw/rtl/sv39ptb_dp.sv */
// Datapath of the Sv39 page table builder: table store, walk registers,
// allocator and result registers. Depends on sv39ptb_pkg.
`default_nettype none

module sv39ptb_dp import sv39ptb_pkg::*; #(
   parameter int POOL_PAGES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_sts_type               sts,
   input  wire logic                csr_wr_en,
   input  wire logic [PPN_W-1:0]    csr_wr_data,
   input  wire logic                in_cmd,
   input  wire logic [VPN_W-1:0]    in_virt_page,
   input  wire logic [PPN_W-1:0]    in_phys_page,
   input  wire logic [CNT_W-1:0]    in_page_count,
   input  wire logic [PERM_W-1:0]   in_permissions,
   output logic [2:0]               out_status,
   output logic [ENTRY_W-1:0]       out_last_entry,
   output logic [CNT_W-1:0]         out_pages_done,
   output logic [USED_W-1:0]        out_pool_pages_used
);

   localparam int PAGE_W = $clog2(POOL_PAGES);
   localparam int NFP_W  = $clog2(POOL_PAGES + 1);
   localparam int ADDR_W = PAGE_W + IDX_W;
   localparam int DEPTH  = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam logic [NFP_W-1:0] POOL_FULL = NFP_W'(POOL_PAGES);

   logic [PPN_W-1:0]   base_ff, base_in;
   logic [NFP_W-1:0]   nfp_ff, nfp_in;
   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;
   level_type          level_ff, level_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic               cmd_ff, cmd_in;
   logic [VPN_W-1:0]   vpn_ff, vpn_in;
   logic [PPN_W-1:0]   ppn_ff, ppn_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PERM_W-1:0]  perm_ff, perm_in;
   logic [CNT_W-1:0]   done_ff, done_in;
   logic [ENTRY_W-1:0] last_ff, last_in;
   status_type         status_ff, status_in;

   logic [ENTRY_W-1:0] rd_data_ff;
   logic [ENTRY_W-1:0] mem_array [DEPTH];

   logic [IDX_W-1:0]   idx;
   logic [ADDR_W-1:0]  cur_addr;
   logic [PPN_W-1:0]   entry_ppn;
   logic [PPN_W-1:0]   rel_page;
   logic [PPN_W-1:0]   nfp_wide;
   logic [PAGE_W-1:0]  fresh_page;
   logic [ENTRY_W-1:0] link_entry;
   logic [ENTRY_W-1:0] leaf_entry;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   level_type          lower_level;
   logic [NFP_W+USED_W-1:0] nfp_ext;

   always_comb begin
      case (level_ff)
         LVL_2:   idx = vpn_ff[3*IDX_W-1:2*IDX_W];
         LVL_1:   idx = vpn_ff[2*IDX_W-1:IDX_W];
         default: idx = vpn_ff[IDX_W-1:0];
      endcase
      case (level_ff)
         LVL_2:   lower_level = LVL_1;
         default: lower_level = LVL_0;
      endcase
   end

   assign cur_addr   = {page_ff, idx};
   assign entry_ppn  = rd_data_ff[FLAG_SHIFT +: PPN_W];
   assign rel_page   = entry_ppn - base_ff;
   assign nfp_wide   = {{(PPN_W-NFP_W){1'b0}}, nfp_ff};
   assign fresh_page = nfp_ff[PAGE_W-1:0];

   // Table entry for a fresh page carries only the U and V flags.
   assign link_entry = {{(ENTRY_W-FLAG_SHIFT-PPN_W){1'b0}}, base_ff + nfp_wide, 2'b00,
                        3'b000, perm_ff[FLAG_U_BIT], 3'b000, perm_ff[FLAG_V_BIT]};

   always_comb begin
      if (cmd_ff == CMD_MARK) begin
         leaf_entry = rd_data_ff | (ENTRY_W'(1) << FLAG_U_BIT);
      end else begin
         leaf_entry = {{(ENTRY_W-FLAG_SHIFT-PPN_W){1'b0}}, ppn_ff, 2'b00, perm_ff};
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_addr;
      wr_data = leaf_entry;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = {(cmd.clr_root ? {PAGE_W{1'b0}} : fresh_page), clr_cnt_ff};
         wr_data = '0;
      end else if (cmd.link) begin
         wr_en   = 1'b1;
         wr_data = link_entry;
      end else if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem_array[cur_addr];
      end
   end

   always_comb begin
      base_in    = csr_wr_en ? csr_wr_data : base_ff;
      nfp_in     = nfp_ff;
      clr_cnt_in = cmd.clr_step ? clr_cnt_ff + IDX_W'(1) : clr_cnt_ff;
      level_in   = level_ff;
      page_in    = page_ff;
      cmd_in     = cmd_ff;
      vpn_in     = vpn_ff;
      ppn_in     = ppn_ff;
      cnt_in     = cnt_ff;
      perm_in    = perm_ff;
      done_in    = done_ff;
      last_in    = last_ff;
      status_in  = cmd.set_st ? cmd.st : status_ff;
      if (cmd.load) begin
         cmd_in    = in_cmd;
         vpn_in    = in_virt_page;
         ppn_in    = in_phys_page;
         cnt_in    = in_page_count;
         perm_in   = in_permissions;
         done_in   = '0;
         last_in   = '0;
         status_in = ST_OK;
         level_in  = LVL_2;
         page_in   = '0;
      end
      if (cmd.descend) begin
         page_in  = rel_page[PAGE_W-1:0];
         level_in = lower_level;
      end
      if (cmd.link) begin
         page_in  = fresh_page;
         nfp_in   = nfp_ff + NFP_W'(1);
         level_in = lower_level;
      end
      if (cmd.leaf_wr) begin
         last_in  = leaf_entry;
         done_in  = done_ff + CNT_W'(1);
         vpn_in   = vpn_ff + VPN_W'(1);
         ppn_in   = ppn_ff + PPN_W'(1);
         level_in = LVL_2;
         page_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= POOL_BASE_RESET;
         nfp_ff     <= NFP_W'(1);
         clr_cnt_ff <= '0;
         level_ff   <= LVL_2;
         page_ff    <= '0;
      end else begin
         base_ff    <= base_in;
         nfp_ff     <= nfp_in;
         clr_cnt_ff <= clr_cnt_in;
         level_ff   <= level_in;
         page_ff    <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      vpn_ff    <= vpn_in;
      ppn_ff    <= ppn_in;
      cnt_ff    <= cnt_in;
      perm_ff   <= perm_in;
      done_ff   <= done_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign nfp_ext = {{USED_W{1'b0}}, nfp_ff};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status          <= status_ff;
         out_last_entry      <= last_ff;
         out_pages_done      <= done_ff;
         out_pool_pages_used <= nfp_ext[USED_W-1:0];
      end
   end

   assign sts.start_empty = (in_cmd == CMD_MAP) && (in_page_count == '0);
   assign sts.entry_zero  = (rd_data_ff == '0);
   assign sts.foreign     = (rel_page >= nfp_wide);
   assign sts.pool_full   = (nfp_ff == POOL_FULL);
   assign sts.level_zero  = (level_ff == LVL_0);
   assign sts.is_mark     = (cmd_ff == CMD_MARK);
   assign sts.last_page   = ((done_ff + CNT_W'(1)) == cnt_ff);
   assign sts.clr_last    = (clr_cnt_ff == '1);

endmodule

`default_nettype wire

/* hw/rtl/sv39_page_table_builder_top.sv */
// Top level of the Sv39 page table builder.
// Depends on sv39ptb_pkg, sv39ptb_req_if, sv39ptb_rsp_if, sv39ptb_ctrl and sv39ptb_dp.
//
//   Channel   Direction  Handshake            Carries
//   req_bus   in         valid/ready          cmd, virt_page, phys_page, page_count, permissions
//   rsp_bus   out        valid/ready          status, last_entry, pages_done, pool_pages_used
//   csr_*     in         csr_wr_en (no wait)  pool_base_page
//
// Each table level is walked with a read state and a check state. While the tables on its
// path exist, a map writes one leaf per page; for each table it creates, it first clears
// the fresh page with a sweep through the single write port and then writes a link entry.
// A mark creates no tables, and a map of zero pages skips the walk and goes straight to the
// done state, which places the response. After reset the root table is swept to zero, which
// holds req_bus.ready low. The response sits in its own register, so the next request is
// taken and worked on while a response is still waiting for rsp_bus.ready.
`default_nettype none

module sv39_page_table_builder_top import sv39ptb_pkg::*; #(
   parameter int POOL_PAGES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   sv39ptb_req_if.sink            req_bus,
   sv39ptb_rsp_if.source          rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [PPN_W-1:0]  csr_wr_data
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   // The controller sequences the walk; it sees only handshakes and datapath status.
   sv39ptb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // The datapath holds the table store, the allocator and the response registers.
   sv39ptb_dp #(
      .POOL_PAGES (POOL_PAGES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .sts                 (dp_sts),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .in_cmd              (req_bus.cmd),
      .in_virt_page        (req_bus.virt_page),
      .in_phys_page        (req_bus.phys_page),
      .in_page_count       (req_bus.page_count),
      .in_permissions      (req_bus.permissions),
      .out_status          (rsp_bus.status),
      .out_last_entry      (rsp_bus.last_entry),
      .out_pages_done      (rsp_bus.pages_done),
      .out_pool_pages_used (rsp_bus.pool_pages_used)
   );

endmodule

`default_nettype wire

/* hw/rtl/sv39ptb_checker.sv */
// Port-level checks of the Sv39 page table builder, bound to the top level.
// Depends on sv39ptb_pkg and sv39_page_table_builder_top.
`default_nettype none

module sv39ptb_checker import sv39ptb_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [2:0]         rsp_status,
   input wire logic [ENTRY_W-1:0] rsp_last_entry,
   input wire logic [CNT_W-1:0]   rsp_pages_done,
   input wire logic [USED_W-1:0]  rsp_pool_pages_used
);

   // A waiting response holds still until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_last_entry) && $stable(rsp_pages_done) && $stable(rsp_pool_pages_used))
      else $error("response changed while stalled");

   // The root table sweep keeps requests out right after reset.
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during root clearing");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FOREIGN)
      else $error("undefined status code");

   // No page written means no leaf value reported.
   a_no_leaf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pages_done == '0 |-> rsp_last_entry == '0)
      else $error("leaf value without a page done");

   a_unmapped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNMAPPED |-> rsp_pages_done == '0)
      else $error("not-mapped response with pages done");

endmodule

bind sv39_page_table_builder_top sv39ptb_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_status          (rsp_bus.status),
   .rsp_last_entry      (rsp_bus.last_entry),
   .rsp_pages_done      (rsp_bus.pages_done),
   .rsp_pool_pages_used (rsp_bus.pool_pages_used)
);

`default_nettype wire
